/* hw/rtl/bwlb_pkg.sv */
// Shared types, codes and constants of the bus window link bridge.
package bwlb_pkg;

  localparam int RegCountDef = 16;
  localparam int MaxRes      = 5;
  localparam int CntW        = 3;
  localparam int MsgDepth    = 7;

  // Control register bit positions
  localparam int CsrTrn  = 15;
  localparam int CsrLnk  = 14;
  localparam int CsrXmit = 12;
  localparam int CsrIe   = 6;

  localparam logic [2:0] RegCsr    = 3'd0;
  localparam logic [2:0] RegReason = 3'd1;
  localparam logic [2:0] RegVector = 3'd7;
  localparam logic [3:0] IdxMask   = 4'hF;

  // Link message types
  localparam logic [7:0] MsgOn    = 8'd1;
  localparam logic [7:0] MsgOff   = 8'd2;
  localparam logic [7:0] MsgIrq   = 8'd3;
  localparam logic [7:0] MsgReg   = 8'd4;
  localparam logic [7:0] MsgRdB   = 8'd5;
  localparam logic [7:0] MsgRdW   = 8'd6;
  localparam logic [7:0] MsgData  = 8'd7;
  localparam logic [7:0] MsgWrB   = 8'd9;
  localparam logic [7:0] MsgWrW   = 8'd10;

  typedef enum logic [2:0] {
    FN_BUS_WR     = 3'd0,
    FN_BUS_RD     = 3'd1,
    FN_LINK_BYTE  = 3'd2,
    FN_MEM_DATA   = 3'd3,
    FN_IRQ_ACK    = 3'd4,
    FN_CONNECT    = 3'd5,
    FN_DISCONNECT = 3'd6,
    FN_NOP        = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    MREQ_NONE  = 2'd0,
    MREQ_READ  = 2'd1,
    MREQ_WRITE = 2'd2
  } mreq_t;

  typedef logic [MaxRes-1:0][7:0] txq_t;

  // Fields shared by every result of one request
  typedef struct packed {
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [15:0] mem_write_data;
    logic        mem_wide;
    logic        irq_request;
    logic        bad_message;
  } common_t;

endpackage

/* hw/rtl/bwlb_if.sv */
// Request and result channel interfaces of the bus window link bridge.
interface bwl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [2:0]  reg_index;
  logic [15:0] write_data;
  logic [7:0]  rx_byte;
  logic [15:0] mem_read_data;

  modport source (output valid, func, reg_index, write_data, rx_byte, mem_read_data,
                  input ready);
  modport sink (input valid, func, reg_index, write_data, rx_byte, mem_read_data,
                output ready);
endinterface

interface bwl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic [1:0]  mem_request;
  logic [31:0] mem_address;
  logic [15:0] mem_write_data;
  logic        mem_wide;
  logic        irq_request;
  logic        bad_message;
  logic        last;

  modport source (output valid, read_data, tx_valid, tx_byte, mem_request, mem_address,
                  mem_write_data, mem_wide, irq_request, bad_message, last,
                  input ready);
  modport sink (input valid, read_data, tx_valid, tx_byte, mem_request, mem_address,
                mem_write_data, mem_wide, irq_request, bad_message, last,
                output ready);
endinterface

/* hw/rtl/bus_window_link_bridge_top.sv */
// An accepted request is registered in the decode stage, then in the output stage.
// Throughput: a request yields max(1, n) results, n = link bytes sent (0..5), one per cycle
// while the result side is ready; the output stage, which presents them, is the limit.
// A new request is taken while earlier results still wait in the output stage.
// Reset is synchronous: the register file reads as its reset values through per-entry
// written flags, so no clearing pass is needed and requests are taken right after reset.
module bus_window_link_bridge_top #(
  parameter int REG_COUNT = bwlb_pkg::RegCountDef
) (
  input logic       clk,
  input logic       rst_n,
  bwl_in_if.sink    in_ch,
  bwl_out_if.source out_ch
);

  localparam int AW = $clog2(REG_COUNT);
  localparam int MsgDepthL = bwlb_pkg::MsgDepth;

  // Architectural state held outside the RAM
  logic [15:0]                 csr_r, csr_nxt;
  logic                        reason_nz_r, reason_nz_nxt;
  logic                        conn_r, conn_nxt;
  logic                        irq_r, irq_nxt;
  logic                        rdp_r, rdp_nxt;
  logic                        rdw_r, rdw_nxt;
  logic [2:0]                  mlen_r, mlen_nxt;
  logic [MsgDepthL-1:0][7:0]   mbuf_r, mbuf_nxt;
  logic [REG_COUNT-1:0]        vld_r, vld_nxt;

  // Register file RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_q;

  // Decode stage
  logic                   s1_valid_r, s1_valid_nxt;
  logic [bwlb_pkg::CntW-1:0] s1_txn_r, s1_txn_nxt;
  bwlb_pkg::txq_t         s1_bytes_r, s1_bytes_nxt;
  bwlb_pkg::common_t      s1_com_r, s1_com_nxt;
  logic                   s1_use_ram_r, s1_use_ram_nxt;
  logic                   s1_hit_r, s1_hit_nxt;
  logic                   s1_one_r, s1_one_nxt;

  // Output stage
  logic                   s2_valid_r, s2_valid_nxt;
  logic [bwlb_pkg::CntW-1:0] s2_rem_r, s2_rem_nxt;
  logic                   s2_txv_r, s2_txv_nxt;
  bwlb_pkg::txq_t         s2_bytes_r, s2_bytes_nxt;
  logic [15:0]            s2_rdata_r, s2_rdata_nxt;
  bwlb_pkg::common_t      s2_com_r, s2_com_nxt;

  logic             in_acc;
  logic             out_hs;
  logic             out_last;
  logic             s2_load;
  bwlb_pkg::func_t  func;

  assign func     = bwlb_pkg::func_t'(in_ch.func);
  assign out_last = (s2_rem_r == bwlb_pkg::CntW'(1));
  assign out_hs   = s2_valid_r && out_ch.ready;
  assign s2_load  = s1_valid_r && (!s2_valid_r || (out_ch.ready && out_last));
  assign in_ch.ready = !s1_valid_r || s2_load;
  assign in_acc   = in_ch.valid && in_ch.ready;

  bwlb_ram #(
    .WIDTH (16),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // Request decode and state update
  always_comb begin
    logic [15:0]             d;
    logic [2:0]              pa;
    logic                    on_x;
    logic                    off_x;
    logic                    xmit_new;
    logic [2:0]              pos;
    logic [2:0]              len;
    logic [MsgDepthL-1:0][7:0] nb;
    logic [7:0]              t;
    logic                    done;
    logic [3:0]              idx;
    logic [15:0]             v;
    logic [2:0]              rsel;

    d        = in_ch.write_data;
    pa       = in_ch.reg_index;
    on_x     = 1'b0;
    off_x    = 1'b0;
    xmit_new = 1'b0;
    pos      = 3'd0;
    len      = 3'd0;
    nb       = mbuf_r;
    t        = 8'd0;
    done     = 1'b1;
    idx      = 4'd0;
    v        = 16'd0;
    rsel     = pa;

    csr_nxt       = csr_r;
    reason_nz_nxt = reason_nz_r;
    conn_nxt      = conn_r;
    irq_nxt       = irq_r;
    rdp_nxt       = rdp_r;
    rdw_nxt       = rdw_r;
    mlen_nxt      = mlen_r;
    mbuf_nxt      = mbuf_r;
    vld_nxt       = vld_r;

    ram_we    = 1'b0;
    ram_waddr = AW'(pa);
    ram_wdata = d;

    s1_txn_nxt   = '0;
    s1_bytes_nxt = '0;
    s1_com_nxt   = '0;
    s1_use_ram_nxt = 1'b0;

    if (in_acc) begin
      case (func)
        bwlb_pkg::FN_BUS_WR: begin
          if (!(pa == bwlb_pkg::RegCsr && reason_nz_r)) begin
            if (pa == bwlb_pkg::RegCsr) begin
              on_x  = !csr_r[bwlb_pkg::CsrXmit] && d[bwlb_pkg::CsrXmit];
              off_x = csr_r[bwlb_pkg::CsrXmit] && !d[bwlb_pkg::CsrXmit];
              if (csr_r[bwlb_pkg::CsrTrn] && !d[bwlb_pkg::CsrTrn]) begin
                irq_nxt = 1'b0;
              end
              csr_nxt  = d;
              xmit_new = d[bwlb_pkg::CsrXmit];
            end else begin
              xmit_new = csr_r[bwlb_pkg::CsrXmit];
            end
            if (pa <= bwlb_pkg::RegReason && d == 16'd0) begin
              irq_nxt = 1'b0;
            end
            if (pa == bwlb_pkg::RegReason) begin
              reason_nz_nxt = (d != 16'd0);
            end
            ram_we    = 1'b1;
            ram_waddr = AW'(pa);
            ram_wdata = d;
            vld_nxt[AW'(pa)] = 1'b1;
            if (conn_r) begin
              if (on_x) begin
                s1_bytes_nxt = {d[7:0], d[15:8], 5'd0, pa, bwlb_pkg::MsgReg,
                                bwlb_pkg::MsgOn};
                s1_txn_nxt   = bwlb_pkg::CntW'(5);
              end else if (off_x) begin
                s1_bytes_nxt[0] = bwlb_pkg::MsgOff;
                s1_txn_nxt      = bwlb_pkg::CntW'(1);
              end else if (xmit_new) begin
                s1_bytes_nxt[0] = bwlb_pkg::MsgReg;
                s1_bytes_nxt[1] = {5'd0, pa};
                s1_bytes_nxt[2] = d[15:8];
                s1_bytes_nxt[3] = d[7:0];
                s1_txn_nxt      = bwlb_pkg::CntW'(4);
              end
            end
          end
        end
        bwlb_pkg::FN_BUS_RD: begin
          s1_use_ram_nxt = 1'b1;
          rsel = pa;
        end
        bwlb_pkg::FN_LINK_BYTE: begin
          if (conn_r) begin
            pos = (mlen_r >= 3'd7) ? 3'd0 : mlen_r;
            len = pos + 3'd1;
            for (int i = 0; i < MsgDepthL; i++) begin
              if (pos == 3'(i)) begin
                nb[i] = in_ch.rx_byte;
              end
            end
            mbuf_nxt = nb;
            t = nb[0];
            case (t)
              bwlb_pkg::MsgOn: begin
                if (!csr_r[bwlb_pkg::CsrLnk]) begin
                  csr_nxt[bwlb_pkg::CsrTrn] = 1'b1;
                  if (csr_r[bwlb_pkg::CsrIe]) irq_nxt = 1'b1;
                end
                csr_nxt[bwlb_pkg::CsrLnk] = 1'b1;
                ram_we = 1'b1;
              end
              bwlb_pkg::MsgOff: begin
                if (csr_r[bwlb_pkg::CsrLnk]) begin
                  csr_nxt[bwlb_pkg::CsrTrn] = 1'b1;
                  if (csr_r[bwlb_pkg::CsrIe]) irq_nxt = 1'b1;
                end
                csr_nxt[bwlb_pkg::CsrLnk] = 1'b0;
                ram_we = 1'b1;
              end
              bwlb_pkg::MsgIrq: begin
                if (csr_r[bwlb_pkg::CsrIe]) irq_nxt = 1'b1;
              end
              bwlb_pkg::MsgReg: begin
                if (len < 3'd4) begin
                  done = 1'b0;
                end else begin
                  idx = nb[1][3:0] & bwlb_pkg::IdxMask;
                  if (32'(idx) < REG_COUNT) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx);
                    ram_wdata = {nb[2], nb[3]};
                    vld_nxt[AW'(idx)] = 1'b1;
                    if (idx == 4'd0) csr_nxt = {nb[2], nb[3]};
                    if (idx == 4'd1) reason_nz_nxt = ({nb[2], nb[3]} != 16'd0);
                  end
                end
              end
              bwlb_pkg::MsgRdB, bwlb_pkg::MsgRdW: begin
                if (len < 3'd5) begin
                  done = 1'b0;
                end else begin
                  s1_com_nxt.mem_request = bwlb_pkg::MREQ_READ;
                  s1_com_nxt.mem_wide    = (t == bwlb_pkg::MsgRdW);
                  rdp_nxt = 1'b1;
                  rdw_nxt = (t == bwlb_pkg::MsgRdW);
                end
              end
              bwlb_pkg::MsgWrB: begin
                if (len < 3'd6) begin
                  done = 1'b0;
                end else begin
                  s1_com_nxt.mem_request    = bwlb_pkg::MREQ_WRITE;
                  s1_com_nxt.mem_write_data = {8'd0, nb[5]};
                end
              end
              bwlb_pkg::MsgWrW: begin
                if (len < 3'd7) begin
                  done = 1'b0;
                end else begin
                  s1_com_nxt.mem_request    = bwlb_pkg::MREQ_WRITE;
                  s1_com_nxt.mem_wide       = 1'b1;
                  s1_com_nxt.mem_write_data = {nb[5], nb[6]};
                end
              end
              default: begin
                s1_com_nxt.bad_message = 1'b1;
              end
            endcase
            // control register write-back for link on and off
            if (t == bwlb_pkg::MsgOn || t == bwlb_pkg::MsgOff) begin
              ram_waddr = AW'(bwlb_pkg::RegCsr);
              ram_wdata = csr_nxt;
              vld_nxt[AW'(bwlb_pkg::RegCsr)] = 1'b1;
            end
            if (s1_com_nxt.mem_request != bwlb_pkg::MREQ_NONE) begin
              s1_com_nxt.mem_address = {nb[1], nb[2], nb[3], nb[4]};
            end
            mlen_nxt = done ? 3'd0 : len;
          end
        end
        bwlb_pkg::FN_MEM_DATA: begin
          if (rdp_r) begin
            v = rdw_r ? in_ch.mem_read_data : {8'd0, in_ch.mem_read_data[7:0]};
            if (conn_r && csr_r[bwlb_pkg::CsrXmit]) begin
              s1_bytes_nxt[0] = bwlb_pkg::MsgData;
              s1_bytes_nxt[1] = v[15:8];
              s1_bytes_nxt[2] = v[7:0];
              s1_txn_nxt      = bwlb_pkg::CntW'(3);
            end
            rdp_nxt = 1'b0;
            rdw_nxt = 1'b0;
          end
        end
        bwlb_pkg::FN_IRQ_ACK: begin
          s1_use_ram_nxt = 1'b1;
          rsel    = bwlb_pkg::RegVector;
          irq_nxt = 1'b0;
        end
        bwlb_pkg::FN_CONNECT: begin
          if (!conn_r) begin
            conn_nxt = 1'b1;
            if (csr_r[bwlb_pkg::CsrXmit]) begin
              s1_bytes_nxt[0] = bwlb_pkg::MsgOn;
              s1_txn_nxt      = bwlb_pkg::CntW'(1);
            end
          end
        end
        bwlb_pkg::FN_DISCONNECT: begin
          conn_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    s1_com_nxt.irq_request = irq_nxt;
    ram_re     = in_acc && s1_use_ram_nxt;
    ram_raddr  = AW'(rsel);
    s1_hit_nxt = vld_r[AW'(rsel)];
    s1_one_nxt = (rsel == bwlb_pkg::RegReason);
  end

  // Stage handoff
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    s2_rem_nxt   = s2_rem_r;
    s2_txv_nxt   = s2_txv_r;
    s2_bytes_nxt = s2_bytes_r;
    s2_rdata_nxt = s2_rdata_r;
    s2_com_nxt   = s2_com_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
      s2_rem_nxt   = (s1_txn_r == '0) ? bwlb_pkg::CntW'(1) : s1_txn_r;
      s2_txv_nxt   = (s1_txn_r != '0);
      s2_bytes_nxt = s1_bytes_r;
      s2_com_nxt   = s1_com_r;
      if (!s1_use_ram_r) begin
        s2_rdata_nxt = 16'd0;
      end else if (s1_hit_r) begin
        s2_rdata_nxt = ram_q;
      end else begin
        s2_rdata_nxt = {15'd0, s1_one_r};
      end
    end else if (out_hs) begin
      if (out_last) begin
        s2_valid_nxt = 1'b0;
      end else begin
        // advance to the next link byte
        s2_rem_nxt   = s2_rem_r - bwlb_pkg::CntW'(1);
        s2_bytes_nxt = {8'd0, s2_bytes_r[bwlb_pkg::MaxRes-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr_r       <= 16'd0;
      reason_nz_r <= 1'b1;
      conn_r      <= 1'b0;
      irq_r       <= 1'b0;
      rdp_r       <= 1'b0;
      rdw_r       <= 1'b0;
      mlen_r      <= 3'd0;
      mbuf_r      <= '0;
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s2_rem_r    <= '0;
    end else begin
      csr_r       <= csr_nxt;
      reason_nz_r <= reason_nz_nxt;
      conn_r      <= conn_nxt;
      irq_r       <= irq_nxt;
      rdp_r       <= rdp_nxt;
      rdw_r       <= rdw_nxt;
      mlen_r      <= mlen_nxt;
      mbuf_r      <= mbuf_nxt;
      vld_r       <= vld_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s2_rem_r    <= s2_rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_txn_r     <= s1_txn_nxt;
      s1_bytes_r   <= s1_bytes_nxt;
      s1_com_r     <= s1_com_nxt;
      s1_use_ram_r <= s1_use_ram_nxt;
      s1_hit_r     <= s1_hit_nxt;
      s1_one_r     <= s1_one_nxt;
    end
    s2_txv_r   <= s2_txv_nxt;
    s2_bytes_r <= s2_bytes_nxt;
    s2_rdata_r <= s2_rdata_nxt;
    s2_com_r   <= s2_com_nxt;
  end

  assign out_ch.valid          = s2_valid_r;
  assign out_ch.read_data      = s2_rdata_r;
  assign out_ch.tx_valid       = s2_txv_r;
  assign out_ch.tx_byte        = s2_txv_r ? s2_bytes_r[0] : 8'd0;
  assign out_ch.mem_request    = s2_com_r.mem_request;
  assign out_ch.mem_address    = s2_com_r.mem_address;
  assign out_ch.mem_write_data = s2_com_r.mem_write_data;
  assign out_ch.mem_wide       = s2_com_r.mem_wide;
  assign out_ch.irq_request    = s2_com_r.irq_request;
  assign out_ch.bad_message    = s2_com_r.bad_message;
  assign out_ch.last           = out_last;

`ifndef NO_ASSERTIONS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_rem_r != '0 && s2_rem_r <= bwlb_pkg::CntW'(bwlb_pkg::MaxRes)))
    else $error("output stage result count out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request not held in decode stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hs && out_last && !s1_valid_r) |=> !s2_valid_r)
    else $error("output stage kept a finished request");

  a_disc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == bwlb_pkg::FN_DISCONNECT) |=> !conn_r)
    else $error("link still connected after disconnect");

  a_irq_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && func == bwlb_pkg::FN_IRQ_ACK) |=> !irq_r)
    else $error("interrupt still pending after acknowledge");
`endif

endmodule

/* hw/rtl/bwlb_ram.sv */
// Generic single write port RAM with a registered, enabled read port.
module bwlb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the bus window link bridge: predicts every result and compares it.
`timescale 1ns / 1ps

module testbench;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;
  localparam int ItemTarget  = 350;

  localparam logic [3:0] CsrIdx    = {1'b0, bwlb_pkg::RegCsr};
  localparam logic [3:0] ReasonIdx = {1'b0, bwlb_pkg::RegReason};
  localparam logic [3:0] VectorIdx = {1'b0, bwlb_pkg::RegVector};

  typedef struct packed {
    bwlb_pkg::func_t func;
    logic [2:0]  reg_index;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;
    logic [15:0] mem_read_data;
  } request_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [15:0] mem_write_data;
    logic        mem_wide;
    logic        irq_request;
    logic        bad_message;
    logic        last;
  } link_result_t;

  class bridge_scoreboard;
    logic [15:0]  regs [16];
    logic [7:0]   msg_bytes [bwlb_pkg::MsgDepth];
    int           msg_count;
    bit           linked;
    bit           irq_level;
    bit           read_waiting;
    bit           read_is_word;
    logic [7:0]   tx_bytes [$];
    link_result_t awaited_results [$];
    int           failures;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[ReasonIdx] = 16'd1;
      foreach (msg_bytes[i]) msg_bytes[i] = '0;
      msg_count    = 0;
      linked       = 0;
      irq_level    = 0;
      read_waiting = 0;
      read_is_word = 0;
      failures     = 0;
    endfunction

    // Bytes go out only while connected and, unless unconditional, with transmit on.
    function void transmit(logic [7:0] b, bit unconditional = 1'b0);
      if (linked && (unconditional || regs[CsrIdx][bwlb_pkg::CsrXmit]) &&
          tx_bytes.size() < bwlb_pkg::MaxRes)
        tx_bytes.push_back(b);
    endfunction

    function void raise_irq();
      if (regs[CsrIdx][bwlb_pkg::CsrIe]) irq_level = 1;
    endfunction

    function int awaited_count();
      return awaited_results.size();
    endfunction

    function void note_request(request_t rq);
      logic [15:0]  rdata, csr, mwdata, v;
      logic [1:0]   mreq;
      logic [31:0]  maddr;
      logic [7:0]   kind;
      logic [3:0]   idx;
      logic         mwide, bad, turn_off, complete;
      int           n;
      link_result_t r;
      tx_bytes.delete();
      rdata  = '0;
      mwdata = '0;
      mreq   = bwlb_pkg::MREQ_NONE;
      maddr  = '0;
      mwide  = 0;
      bad    = 0;
      case (rq.func)
        bwlb_pkg::FN_BUS_WR: begin
          if (!(rq.reg_index == bwlb_pkg::RegCsr && regs[ReasonIdx] != 0)) begin
            csr      = regs[CsrIdx];
            turn_off = 0;
            if (rq.reg_index == bwlb_pkg::RegCsr) begin
              if (!csr[bwlb_pkg::CsrXmit] && rq.write_data[bwlb_pkg::CsrXmit]) begin
                regs[CsrIdx][bwlb_pkg::CsrXmit] = 1'b1;
                transmit(bwlb_pkg::MsgOn);
              end
              turn_off = csr[bwlb_pkg::CsrXmit] && !rq.write_data[bwlb_pkg::CsrXmit];
              if (csr[bwlb_pkg::CsrTrn] && !rq.write_data[bwlb_pkg::CsrTrn]) irq_level = 0;
            end
            if (rq.reg_index <= bwlb_pkg::RegReason && rq.write_data == 0) irq_level = 0;
            regs[{1'b0, rq.reg_index}] = rq.write_data;
            transmit(bwlb_pkg::MsgReg);
            transmit({5'd0, rq.reg_index});
            transmit(rq.write_data[15:8]);
            transmit(rq.write_data[7:0]);
            if (turn_off) transmit(bwlb_pkg::MsgOff, 1'b1);
          end
        end
        bwlb_pkg::FN_BUS_RD: rdata = regs[{1'b0, rq.reg_index}];
        bwlb_pkg::FN_LINK_BYTE: begin
          if (linked) begin
            complete = 1;
            if (msg_count >= bwlb_pkg::MsgDepth) msg_count = 0;
            msg_bytes[3'(msg_count)] = rq.rx_byte;
            msg_count++;
            kind  = msg_bytes[0];
            maddr = {msg_bytes[1], msg_bytes[2], msg_bytes[3], msg_bytes[4]};
            case (kind)
              bwlb_pkg::MsgOn: begin
                if (!regs[CsrIdx][bwlb_pkg::CsrLnk]) begin
                  regs[CsrIdx][bwlb_pkg::CsrTrn] = 1'b1;
                  raise_irq();
                end
                regs[CsrIdx][bwlb_pkg::CsrLnk] = 1'b1;
              end
              bwlb_pkg::MsgOff: begin
                if (regs[CsrIdx][bwlb_pkg::CsrLnk]) begin
                  regs[CsrIdx][bwlb_pkg::CsrTrn] = 1'b1;
                  raise_irq();
                end
                regs[CsrIdx][bwlb_pkg::CsrLnk] = 1'b0;
              end
              bwlb_pkg::MsgIrq: raise_irq();
              bwlb_pkg::MsgReg: begin
                if (msg_count < 4) begin
                  complete = 0;
                end else begin
                  idx = msg_bytes[1][3:0] & bwlb_pkg::IdxMask;
                  if (idx < bwlb_pkg::RegCountDef) regs[idx] = {msg_bytes[2], msg_bytes[3]};
                end
              end
              bwlb_pkg::MsgRdB, bwlb_pkg::MsgRdW: begin
                if (msg_count < 5) begin
                  complete = 0;
                end else begin
                  mreq         = bwlb_pkg::MREQ_READ;
                  mwide        = (kind == bwlb_pkg::MsgRdW);
                  read_waiting = 1;
                  read_is_word = (kind == bwlb_pkg::MsgRdW);
                end
              end
              bwlb_pkg::MsgWrB: begin
                if (msg_count < 6) begin
                  complete = 0;
                end else begin
                  mreq   = bwlb_pkg::MREQ_WRITE;
                  mwdata = {8'd0, msg_bytes[5]};
                end
              end
              bwlb_pkg::MsgWrW: begin
                if (msg_count < 7) begin
                  complete = 0;
                end else begin
                  mreq   = bwlb_pkg::MREQ_WRITE;
                  mwide  = 1;
                  mwdata = {msg_bytes[5], msg_bytes[6]};
                end
              end
              default: bad = 1;
            endcase
            if (mreq == bwlb_pkg::MREQ_NONE) maddr = '0;
            if (complete) msg_count = 0;
          end
        end
        bwlb_pkg::FN_MEM_DATA: begin
          if (read_waiting) begin
            v = read_is_word ? rq.mem_read_data : {8'd0, rq.mem_read_data[7:0]};
            transmit(bwlb_pkg::MsgData);
            transmit(v[15:8]);
            transmit(v[7:0]);
            read_waiting = 0;
            read_is_word = 0;
          end
        end
        bwlb_pkg::FN_IRQ_ACK: begin
          rdata     = regs[VectorIdx];
          irq_level = 0;
        end
        bwlb_pkg::FN_CONNECT: begin
          if (!linked) begin
            linked = 1;
            transmit(bwlb_pkg::MsgOn);
          end
        end
        bwlb_pkg::FN_DISCONNECT: linked = 0;
        default: ;
      endcase
      n = (tx_bytes.size() > 0) ? tx_bytes.size() : 1;
      for (int k = 0; k < n; k++) begin
        r.read_data      = rdata;
        r.tx_valid       = (tx_bytes.size() > 0);
        r.tx_byte        = (tx_bytes.size() > 0) ? tx_bytes[k] : 8'd0;
        r.mem_request    = mreq;
        r.mem_address    = maddr;
        r.mem_write_data = mwdata;
        r.mem_wide       = mwide;
        r.irq_request    = irq_level;
        r.bad_message    = bad;
        r.last           = (k == n - 1);
        awaited_results.push_back(r);
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(link_result_t got);
      link_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      compare("read_data", 32'(want.read_data), 32'(got.read_data));
      compare("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
      compare("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      compare("mem_request", 32'(want.mem_request), 32'(got.mem_request));
      compare("mem_address", want.mem_address, got.mem_address);
      compare("mem_write_data", 32'(want.mem_write_data), 32'(got.mem_write_data));
      compare("mem_wide", 32'(want.mem_wide), 32'(got.mem_wide));
      compare("irq_request", 32'(want.irq_request), 32'(got.irq_request));
      compare("bad_message", 32'(want.bad_message), 32'(got.bad_message));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   sent_count;
  int   idle_cycles;

  bridge_scoreboard sb;

  bwl_in_if  in_ch();
  bwl_out_if out_ch();

  bus_window_link_bridge_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Stall the result side at random, except during the calm stretch.
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 14);
  end

  always @(posedge clk) begin
    bit           took;
    request_t     rq;
    link_result_t res;
    took = 0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        rq.func          = bwlb_pkg::func_t'(in_ch.func);
        rq.reg_index     = in_ch.reg_index;
        rq.write_data    = in_ch.write_data;
        rq.rx_byte       = in_ch.rx_byte;
        rq.mem_read_data = in_ch.mem_read_data;
        sb.note_request(rq);
        took = 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        res.read_data      = out_ch.read_data;
        res.tx_valid       = out_ch.tx_valid;
        res.tx_byte        = out_ch.tx_byte;
        res.mem_request    = out_ch.mem_request;
        res.mem_address    = out_ch.mem_address;
        res.mem_write_data = out_ch.mem_write_data;
        res.mem_wide       = out_ch.mem_wide;
        res.irq_request    = out_ch.irq_request;
        res.bad_message    = out_ch.bad_message;
        res.last           = out_ch.last;
        sb.check_result(res);
        took = 1;
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] random_byte();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic request_t random_request(bwlb_pkg::func_t f);
    request_t rq;
    rq.func          = f;
    rq.reg_index     = 3'($urandom_range(7));
    rq.write_data    = 16'($urandom);
    rq.rx_byte       = 8'($urandom);
    rq.mem_read_data = 16'($urandom);
    return rq;
  endfunction

  task automatic send_request(request_t rq);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= rq.func;
    in_ch.reg_index     <= rq.reg_index;
    in_ch.write_data    <= rq.write_data;
    in_ch.rx_byte       <= rq.rx_byte;
    in_ch.mem_read_data <= rq.mem_read_data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_func(bwlb_pkg::func_t f);
    send_request(random_request(f));
  endtask

  task automatic bus_write(logic [2:0] idx, logic [15:0] d);
    request_t rq;
    rq            = random_request(bwlb_pkg::FN_BUS_WR);
    rq.reg_index  = idx;
    rq.write_data = d;
    send_request(rq);
  endtask

  task automatic link_byte(logic [7:0] b);
    request_t rq;
    rq         = random_request(bwlb_pkg::FN_LINK_BYTE);
    rq.rx_byte = b;
    send_request(rq);
  endtask

  task automatic mem_data(logic [15:0] v);
    request_t rq;
    rq               = random_request(bwlb_pkg::FN_MEM_DATA);
    rq.mem_read_data = v;
    send_request(rq);
  endtask

  // Send a link message of the given type; a cut one stops short of its full length.
  task automatic send_link_message(logic [7:0] kind, bit cut);
    int len;
    case (kind)
      bwlb_pkg::MsgReg:                   len = 4;
      bwlb_pkg::MsgRdB, bwlb_pkg::MsgRdW: len = 5;
      bwlb_pkg::MsgWrB:                   len = 6;
      bwlb_pkg::MsgWrW:                   len = 7;
      default:                            len = 1;
    endcase
    if (cut && len > 1) len = int'($urandom_range(len - 1, 1));
    link_byte(kind);
    for (int i = 1; i < len; i++) link_byte(random_byte());
  endtask

  task automatic random_scenario();
    int          pick;
    logic [7:0]  kinds [8];
    logic [7:0]  kind;
    logic [15:0] d;
    request_t    rq;
    kinds = '{bwlb_pkg::MsgOn, bwlb_pkg::MsgOff, bwlb_pkg::MsgIrq, bwlb_pkg::MsgReg,
              bwlb_pkg::MsgRdB, bwlb_pkg::MsgRdW, bwlb_pkg::MsgWrB, bwlb_pkg::MsgWrW};
    pick  = int'($urandom_range(99));
    if (pick < 35) begin
      kind = kinds[3'($urandom_range(7))];
      send_link_message(kind, 1'b0);
      if ((kind == bwlb_pkg::MsgRdB || kind == bwlb_pkg::MsgRdW) && $urandom_range(9) < 7)
        mem_data(16'($urandom));
    end else if (pick < 40) begin
      if ($urandom_range(1)) send_link_message(kinds[3'($urandom_range(7))], 1'b1);
      else link_byte(8'($urandom_range(255)));
    end else if (pick < 60) begin
      if ($urandom_range(3) == 0) bus_write(bwlb_pkg::RegReason, 16'd0);
      d = 16'($urandom);
      if ($urandom_range(1)) d[bwlb_pkg::CsrIe] = 1'b1;
      if ($urandom_range(2) == 0) bus_write(3'($urandom_range(7)), d);
      else bus_write(bwlb_pkg::RegCsr, d);
    end else if (pick < 70) begin
      send_func(bwlb_pkg::FN_BUS_RD);
    end else if (pick < 75) begin
      send_func(bwlb_pkg::FN_IRQ_ACK);
    end else if (pick < 83) begin
      mem_data(16'($urandom));
    end else if (pick < 90) begin
      send_func(bwlb_pkg::FN_CONNECT);
    end else if (pick < 94) begin
      send_func(bwlb_pkg::FN_DISCONNECT);
    end else if (pick < 97) begin
      link_byte(random_byte());
    end else begin
      rq      = random_request(bwlb_pkg::FN_NOP);
      rq.func = bwlb_pkg::func_t'(3'($urandom_range(7)));
      send_request(rq);
    end
  endtask

  initial begin
    sb                  = new();
    clk                 = 0;
    rst_n               = 0;
    calm                = 0;
    sent_count          = 0;
    idle_cycles         = 0;
    in_ch.valid         = 0;
    in_ch.func          = bwlb_pkg::FN_NOP;
    in_ch.reg_index     = '0;
    in_ch.write_data    = '0;
    in_ch.rx_byte       = '0;
    in_ch.mem_read_data = '0;
    out_ch.ready        = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reason register starts nonzero, so the first control write must be dropped.
    send_func(bwlb_pkg::FN_BUS_RD);
    bus_write(bwlb_pkg::RegCsr, 16'hFFFF);
    send_func(bwlb_pkg::FN_CONNECT);
    send_func(bwlb_pkg::FN_CONNECT);
    bus_write(bwlb_pkg::RegReason, 16'd0);
    bus_write(bwlb_pkg::RegCsr, 16'h1040);
    link_byte(bwlb_pkg::MsgOn);
    link_byte(bwlb_pkg::MsgIrq);
    link_byte(8'h00);
    link_byte(8'hFF);
    bus_write(bwlb_pkg::RegVector, 16'hFFFF);
    send_func(bwlb_pkg::FN_IRQ_ACK);
    link_byte(bwlb_pkg::MsgReg);
    repeat (3) link_byte(8'hFF);
    link_byte(bwlb_pkg::MsgRdW);
    repeat (4) link_byte(8'hFF);
    mem_data(16'hFFFF);
    mem_data(16'h0000);
    // Clearing transmit and transition drops the interrupt and sends only the off byte.
    bus_write(bwlb_pkg::RegCsr, 16'h0000);
    link_byte(bwlb_pkg::MsgOff);
    send_func(bwlb_pkg::FN_DISCONNECT);
    link_byte(bwlb_pkg::MsgOn);
    send_func(bwlb_pkg::FN_NOP);

    send_func(bwlb_pkg::FN_CONNECT);
    bus_write(bwlb_pkg::RegCsr, 16'h1040);
    while (sent_count < ItemTarget) begin
      calm = (sent_count >= 150 && sent_count < 240);
      random_scenario();
    end
    calm = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.awaited_count() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bwlb_pkg.sv
hw/rtl/bwlb_if.sv
hw/rtl/bwlb_ram.sv
hw/rtl/bus_window_link_bridge_top.sv
test/testbench.sv
